@@ src/glcs_pkg.sv @@
package glcs_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SIZE_W      = 11;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int COUNT_W     = 20;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(3);

  localparam logic [3:0] BIRTH_SUM   = 4'd3;
  localparam logic [3:0] SURVIVE_SUM = 4'd2;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } glcs_reg_t;

  // one interior cell on its way from the window to the rule stage
  typedef struct packed {
    logic             centre;
    logic [3:0]       sum;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } glcs_rec_t;

endpackage

@@ src/glcs_front.sv @@
module glcs_front import glcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic              push,
  input  logic              cell_alive,
  output logic              full,
  output logic              rec_valid,
  output glcs_rec_t         rec,
  input  logic              rec_full
);

  logic [SIZE_W-1:0] grid_width;
  logic [SIZE_W-1:0] grid_height;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [COL_W-1:0]  col_last;
  logic [ROW_W-1:0]  row_last;

  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;

  // line store entry: bit 0 upper row, bit 1 middle row
  logic [1:0]        lines [MAX_WIDTH];
  logic [1:0]        rd_data;

  logic              s1_valid;
  logic              s1_cur;
  logic [ROW_W-1:0]  s1_row;
  logic [COL_W-1:0]  s1_col;
  logic [5:0]        window_bits;

  logic              accept;
  logic              fire;
  logic              emit;
  logic [2:0]        col3;
  logic [2:0]        older;
  logic [2:0]        prev;
  logic [3:0]        sum;

  always_comb begin
    if (grid_width < MIN_SIZE) begin
      w_eff = MIN_SIZE;
    end else if (grid_width > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height < MIN_SIZE) begin
      h_eff = MIN_SIZE;
    end else if (grid_height > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height;
    end
  end

  assign col_last = COL_W'(w_eff - SIZE_W'(1));
  assign row_last = ROW_W'(h_eff - SIZE_W'(1));

  assign emit   = (s1_row >= ROW_W'(2)) && (s1_col >= COL_W'(2));
  assign fire   = s1_valid && (!emit || !rec_full);
  assign full   = s1_valid && !fire;
  assign accept = push && !full;

  assign col3  = {s1_cur, rd_data[1], rd_data[0]};
  assign older = window_bits[2:0];
  assign prev  = window_bits[5:3];
  assign sum   = 4'(older[0]) + 4'(older[1]) + 4'(older[2])
               + 4'(col3[0]) + 4'(col3[1]) + 4'(col3[2])
               + 4'(prev[0]) + 4'(prev[2]);

  assign rec_valid  = fire && emit;
  assign rec.centre = prev[1];
  assign rec.sum    = sum;
  assign rec.row    = s1_row - ROW_W'(1);
  assign rec.col    = s1_col - COL_W'(1);
  assign rec.last   = (s1_row == row_last) && (s1_col == col_last);

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= lines[col];
    end
    if (fire) begin
      lines[s1_col] <= {s1_cur, rd_data[1]};
    end
    if (accept) begin
      s1_cur <= cell_alive;
      s1_row <= row;
      s1_col <= col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_W'(MAX_WIDTH);
      grid_height <= SIZE_W'(MAX_HEIGHT);
      row         <= '0;
      col         <= '0;
      s1_valid    <= 1'b0;
      window_bits <= '0;
    end else if (cfg_we) begin
      // a register write restarts the frame
      case (glcs_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default:         grid_width  <= grid_width;
      endcase
      row         <= '0;
      col         <= '0;
      s1_valid    <= 1'b0;
      window_bits <= '0;
    end else begin
      if (fire) begin
        window_bits <= {col3, prev};
      end
      if (accept) begin
        s1_valid <= 1'b1;
        if (col == col_last) begin
          col <= '0;
          row <= (row == row_last) ? '0 : row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/glcs_queue.sv @@
module glcs_queue import glcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  glcs_rec_t wr_rec,
  output logic      q_full,
  input  logic      rd,
  output glcs_rec_t rd_rec,
  output logic      q_empty
);

  glcs_rec_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_rec  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/glcs_back.sv @@
module glcs_back import glcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               restart,
  input  glcs_rec_t          rec,
  input  logic               rec_empty,
  output logic               rec_take,
  output logic               empty,
  input  logic               pop,
  output logic               next_alive,
  output logic [ROW_W-1:0]   cell_row,
  output logic [COL_W-1:0]   cell_col,
  output logic               last_cell,
  output logic [COUNT_W-1:0] live_total
);

  logic               out_valid;
  logic [COUNT_W-1:0] live_counter;
  logic [COUNT_W-1:0] live_sum;
  logic               alive;

  assign alive    = (rec.sum == BIRTH_SUM) || (rec.centre && rec.sum == SURVIVE_SUM);
  assign live_sum = live_counter + COUNT_W'(alive);
  assign rec_take = !rec_empty && (!out_valid || pop);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rec_take) begin
      next_alive <= alive;
      cell_row   <= rec.row;
      cell_col   <= rec.col;
      last_cell  <= rec.last;
      live_total <= live_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      out_valid    <= 1'b0;
      live_counter <= '0;
    end else begin
      if (rec_take) begin
        out_valid <= 1'b1;
        // clear the count once the generation's last cell is out
        live_counter <= rec.last ? '0 : live_sum;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/life_generation_stencil.sv @@
// Channel  | Handshake                 | Beat
// ---------+---------------------------+------------------------------------------
// input    | push / full               | cell_alive
// result   | pop / empty               | next_alive, cell_row, cell_col,
//          |                           | last_cell, live_total
// config   | cfg_we, cfg_index         | cfg_data (0 grid_width, 1 grid_height)
//
// One cell is taken per cycle while full is low; a result passes the line store
// read, the window and sum into the queue, and the rule and count register.
// Border cells give no result. A four-entry queue sits between the window
// stage and the result register, so a stalled pop only holds full once it fills.
// Reset (synchronous, rst) and any register write restart the frame at (0,0).
// Line stores are not cleared; border rows never reach a result.
module life_generation_stencil import glcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [SIZE_W-1:0]  cfg_data,
  input  logic               push,
  input  logic               cell_alive,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output logic               next_alive,
  output logic [ROW_W-1:0]   cell_row,
  output logic [COL_W-1:0]   cell_col,
  output logic               last_cell,
  output logic [COUNT_W-1:0] live_total
);

  glcs_rec_t front_rec;
  glcs_rec_t queue_rec;
  logic      front_valid;
  logic      q_full;
  logic      q_empty;
  logic      q_take;

  glcs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .cell_alive (cell_alive),
    .full       (full),
    .rec_valid  (front_valid),
    .rec        (front_rec),
    .rec_full   (q_full)
  );

  glcs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (front_valid),
    .wr_rec  (front_rec),
    .q_full  (q_full),
    .rd      (q_take),
    .rd_rec  (queue_rec),
    .q_empty (q_empty)
  );

  glcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .restart    (cfg_we),
    .rec        (queue_rec),
    .rec_empty  (q_empty),
    .rec_take   (q_take),
    .empty      (empty),
    .pop        (pop),
    .next_alive (next_alive),
    .cell_row   (cell_row),
    .cell_col   (cell_col),
    .last_cell  (last_cell),
    .live_total (live_total)
  );

endmodule

@@ tb/sv/life_generation_stencil_tb.sv @@
`timescale 1ns / 100ps

module life_generation_stencil_tb;
  import glcs_pkg::*;

  typedef struct packed {
    logic               alive;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               last;
    logic [COUNT_W-1:0] total;
  } life_result_t;

  // Next-generation predictor plus the queue of results it expects.
  class life_scoreboard;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    bit                upper_row[MAX_WIDTH];
    bit                middle_row[MAX_WIDTH];
    bit [5:0]          window;
    int unsigned       row_pos;
    int unsigned       col_pos;
    bit [20:0]         live_count;
    life_result_t      expected_q[$];
    int                errors;

    function new();
      width_reg  = SIZE_W'(MAX_WIDTH);
      height_reg = SIZE_W'(MAX_HEIGHT);
      errors     = 0;
      restart();
    endfunction

    function void restart();
      window     = '0;
      row_pos    = 0;
      col_pos    = 0;
      live_count = '0;
    endfunction

    function int unsigned effective(logic [SIZE_W-1:0] v, int unsigned limit);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > limit) return limit;
      return v;
    endfunction

    function void write_reg(glcs_reg_t idx, logic [SIZE_W-1:0] val);
      if (idx == REG_GRID_WIDTH) width_reg = val;
      else height_reg = val;
      restart();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_cell(logic alive);
      int unsigned  w;
      int unsigned  h;
      int unsigned  sum;
      bit [2:0]     col3;
      bit [2:0]     older;
      bit [2:0]     prev;
      bit           nxt;
      life_result_t res;
      w     = effective(width_reg, MAX_WIDTH);
      h     = effective(height_reg, MAX_HEIGHT);
      // bit 0 upper row, bit 1 middle row, bit 2 incoming row
      col3  = {alive, middle_row[col_pos], upper_row[col_pos]};
      older = window[2:0];
      prev  = window[5:3];
      if (row_pos >= 2 && col_pos >= 2) begin
        sum = older[0] + older[1] + older[2] + col3[0] + col3[1] + col3[2]
              + prev[0] + prev[2];
        nxt = (sum == BIRTH_SUM) || (prev[1] && sum == SURVIVE_SUM);
        live_count = live_count + nxt;
        res.alive = nxt;
        res.row   = ROW_W'(row_pos - 1);
        res.col   = COL_W'(col_pos - 1);
        res.last  = (row_pos == h - 1) && (col_pos == w - 1);
        res.total = live_count[COUNT_W-1:0];
        expected_q.push_back(res);
      end
      window = {col3, prev};
      upper_row[col_pos]  = middle_row[col_pos];
      middle_row[col_pos] = alive;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) begin
          row_pos    = 0;
          live_count = '0;
        end
      end
    endfunction

    function void check_result(life_result_t got);
      life_result_t want;
      if (expected_q.size() == 0) begin
        $error("result for row %0d col %0d with nothing expected", got.row, got.col);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.alive !== want.alive) begin
        $error("next_alive: expected %0d, got %0d", want.alive, got.alive);
        errors++;
      end
      if (got.row !== want.row) begin
        $error("cell_row: expected %0d, got %0d", want.row, got.row);
        errors++;
      end
      if (got.col !== want.col) begin
        $error("cell_col: expected %0d, got %0d", want.col, got.col);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_cell: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
      if (got.total !== want.total) begin
        $error("live_total: expected %0d, got %0d", want.total, got.total);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_GRID_WIDTH;
  logic [SIZE_W-1:0]  cfg_data = '0;
  logic               push = 1'b0;
  logic               cell_alive = 1'b0;
  logic               full;
  logic               empty;
  logic               pop = 1'b0;
  logic               next_alive;
  logic [ROW_W-1:0]   cell_row;
  logic [COL_W-1:0]   cell_col;
  logic               last_cell;
  logic [COUNT_W-1:0] live_total;

  life_scoreboard board;
  int                 snd_idle_pct = 0;
  int                 rcv_idle_pct = 0;
  int                 hold_seq = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;
  int unsigned        cells_sent = 0;

  life_generation_stencil i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .cell_alive (cell_alive),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .next_alive (next_alive),
    .cell_row   (cell_row),
    .cell_col   (cell_col),
    .last_cell  (last_cell),
    .live_total (live_total)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) board.note_cell(cell_alive);
      if (pop && !empty)
        board.check_result({next_alive, cell_row, cell_col, last_cell, live_total});
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = 300;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  task automatic set_grid(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, bit [1:0] which);
    if (which[0]) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_GRID_WIDTH;
      cfg_data  <= w;
      @(posedge clk);
      board.write_reg(REG_GRID_WIDTH, w);
    end
    if (which[1]) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_GRID_HEIGHT;
      cfg_data  <= h;
      @(posedge clk);
      board.write_reg(REG_GRID_HEIGHT, h);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_cell(logic v);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    cell_alive <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    cells_sent++;
  endtask

  // Hold the input until every result is in, then let the border cells flush
  task automatic drain();
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    if ($urandom_range(0, 9) == 0) return SIZE_W'($urandom_range(0, 2));
    return SIZE_W'($urandom_range(3, 12));
  endfunction

  task automatic random_phase(bit hold_off);
    logic [SIZE_W-1:0] w_val;
    logic [SIZE_W-1:0] h_val;
    bit [1:0]          which;
    int unsigned       total;
    int unsigned       density;
    w_val = pick_size();
    h_val = pick_size();
    which = 2'($urandom_range(1, 3));
    if (hold_off) begin
      w_val = SIZE_W'(12);
      h_val = SIZE_W'(12);
      which = 2'b11;
    end
    set_grid(w_val, h_val, which);
    total = $urandom_range(1, 3) * board.effective(board.width_reg, MAX_WIDTH)
            * board.effective(board.height_reg, MAX_HEIGHT);
    // cut some frames short so the next write restarts mid-generation
    if (!hold_off && $urandom_range(0, 3) == 0) total = $urandom_range(1, total);
    density = $urandom_range(5, 95);
    if (hold_off) hold_seq++;
    repeat (total) send_cell($urandom_range(0, 99) < density);
    drain();
  endtask

  task automatic send_pattern(bit [8:0] cells);
    for (int i = 0; i < 9; i++) send_cell(cells[i]);
  endtask

  initial begin
    int unsigned start;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 3x3 from undersized values; three generations back to back
    set_grid(SIZE_W'(0), SIZE_W'(2), 2'b11);
    send_pattern(9'b100010001);   // survival on two neighbours
    send_pattern(9'b100000011);   // birth on three
    send_pattern(9'b111111111);   // overcrowding
    drain();

    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          snd_idle_pct = 29;
          rcv_idle_pct = 85;
        end
        1: begin
          snd_idle_pct = 85;
          rcv_idle_pct = 29;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      start = cells_sent;
      random_phase(regime == 2);
      while (cells_sent - start < 160) random_phase(1'b0);
    end

    // oversized values clamp to the maximum; part of the first row only
    set_grid(SIZE_W'(2047), SIZE_W'(2047), 2'b11);
    repeat (64) send_cell(1'($urandom_range(0, 1)));
    drain();

    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
src/glcs_pkg.sv
src/glcs_front.sv
src/glcs_queue.sv
src/glcs_back.sv
src/life_generation_stencil.sv
tb/sv/life_generation_stencil_tb.sv
